/* rtl/isa_pkg.sv */
// ============================================================================
// isa_pkg - shared types and constants for the indexed shift array
// Field widths, operation and status codes, cell commands, the controller
// states and the sizing functions of the registered read tree.
// ============================================================================
package isa_pkg;

    // Transaction field widths (fixed by the interface)
    localparam int FUNC_W     = 3;
    localparam int POSITION_W = 9;
    localparam int WORD_W     = 32;
    localparam int COUNT_W    = 9;
    localparam int STATUS_W   = 2;

    // Internal index width: covers any capacity up to 65536 plus one
    localparam int POS_W = 17;

    // Read tree fan-in per registered level
    localparam int TREE_RADIX_BITS = 4;
    localparam int TREE_RADIX      = 1 << TREE_RADIX_BITS;

    typedef enum logic [FUNC_W-1:0] {
        OP_APPEND = 3'd0,
        OP_READ   = 3'd1,
        OP_WRITE  = 3'd2,
        OP_INSERT = 3'd3,
        OP_DELETE = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_WRITE,
        CMD_INSERT,
        CMD_DELETE
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t        kind;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] len;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT,
        S_OUT
    } fsm_t;

    // Node count of tree level lvl (level 0 = leaves)
    function automatic int tree_nodes(input int n, input int lvl);
        int m;
        m = n;
        for (int i = 0; i < lvl; i++) begin
            m = (m + TREE_RADIX - 1) >> TREE_RADIX_BITS;
        end
        return m;
    endfunction

    // Number of registered levels down to a single root (at least one)
    function automatic int tree_levels(input int n);
        int m;
        int c;
        m = n;
        c = 0;
        do begin
            m = (m + TREE_RADIX - 1) >> TREE_RADIX_BITS;
            c++;
        end while (m > 1);
        return c;
    endfunction

    // Flat offset of level lvl (lvl >= 1) in the tree register array
    function automatic int tree_offset(input int n, input int lvl);
        int s;
        s = 0;
        for (int i = 1; i < lvl; i++) begin
            s += tree_nodes(n, i);
        end
        return s;
    endfunction

endpackage

/* rtl/isa_if.sv */
// ============================================================================
// isa_if - transaction channels of the indexed shift array
// Request channel (operation, position, word) and response channel
// (word read, element count, status), each with valid/ready.
// ============================================================================
interface isa_in_if;
    logic                             valid;
    logic                             ready;
    logic [isa_pkg::FUNC_W-1:0]       func;
    logic [isa_pkg::POSITION_W-1:0]   position;
    logic [isa_pkg::WORD_W-1:0]       word_in;

    modport source (output valid, func, position, word_in, input ready);
    modport sink   (input valid, func, position, word_in, output ready);
endinterface

interface isa_out_if;
    logic                             valid;
    logic                             ready;
    logic [isa_pkg::WORD_W-1:0]       word_out;
    logic [isa_pkg::COUNT_W-1:0]      count;
    logic [isa_pkg::STATUS_W-1:0]     status;

    modport source (output valid, word_out, count, status, input ready);
    modport sink   (input valid, word_out, count, status, output ready);
endinterface

/* rtl/isa_cell.sv */
// ============================================================================
// isa_cell - one element slot of the shift array
// Holds one word; loads the broadcast word, its lower neighbor (insert)
// or its upper neighbor (delete). Drives its word onto the read tree when
// its index matches the requested position.
// ============================================================================
module isa_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int INDEX      = 0
) (
    input  logic                     clk,
    input  isa_pkg::cell_ctrl_t      ctrl,
    input  logic [DATA_WIDTH-1:0]    word,
    input  logic [DATA_WIDTH-1:0]    lower_data,
    input  logic [DATA_WIDTH-1:0]    upper_data,
    output logic [DATA_WIDTH-1:0]    data,
    output logic [DATA_WIDTH-1:0]    leaf
);

    localparam logic [isa_pkg::POS_W-1:0] IDX = isa_pkg::POS_W'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  hit;

    assign hit = (IDX == ctrl.pos);

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.kind)
            isa_pkg::CMD_WRITE:
            begin
                if (hit)
                begin
                    data_next = word;
                end
            end
            isa_pkg::CMD_INSERT:
            begin
                if (hit)
                begin
                    data_next = word;
                end
                else if ((IDX > ctrl.pos) && (IDX <= ctrl.len))
                begin
                    data_next = lower_data;
                end
            end
            isa_pkg::CMD_DELETE:
            begin
                if ((IDX >= ctrl.pos) && ((IDX + 1'b1) < ctrl.len))
                begin
                    data_next = upper_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // Payload only, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign leaf = hit ? data_reg : '0;

endmodule

/* rtl/isa_read_tree.sv */
// ============================================================================
// isa_read_tree - registered OR-reduction of the cell read leaves
// Radix-16 tree, one register level per stage; at most one leaf is
// nonzero, so the root carries the selected word.
// ============================================================================
module isa_read_tree #(
    parameter int DATA_WIDTH = 32,
    parameter int CAPACITY   = 256
) (
    input  logic                     clk,
    input  logic [DATA_WIDTH-1:0]    leaf [CAPACITY],
    output logic [DATA_WIDTH-1:0]    root
);

    localparam int LEVELS = isa_pkg::tree_levels(CAPACITY);
    localparam int TOTAL  = isa_pkg::tree_offset(CAPACITY, LEVELS + 1);
    localparam int RADIX  = isa_pkg::TREE_RADIX;

    logic [DATA_WIDTH-1:0] tree_reg [TOTAL];

    for (genvar l = 0; l < LEVELS; l++)
    begin : g_lvl
        localparam int SRC_N   = isa_pkg::tree_nodes(CAPACITY, l);
        localparam int DST_N   = isa_pkg::tree_nodes(CAPACITY, l + 1);
        localparam int SRC_OFF = isa_pkg::tree_offset(CAPACITY, l);
        localparam int DST_OFF = isa_pkg::tree_offset(CAPACITY, l + 1);

        for (genvar j = 0; j < DST_N; j++)
        begin : g_node
            logic [DATA_WIDTH-1:0] kid [RADIX];
            logic [DATA_WIDTH-1:0] acc;

            for (genvar k = 0; k < RADIX; k++)
            begin : g_kid
                if (j * RADIX + k >= SRC_N)
                begin : g_pad
                    assign kid[k] = '0;
                end
                else if (l == 0)
                begin : g_leaf
                    assign kid[k] = leaf[j * RADIX + k];
                end
                else
                begin : g_inner
                    assign kid[k] = tree_reg[SRC_OFF + j * RADIX + k];
                end
            end

            always_comb
            begin
                acc = '0;
                for (int k = 0; k < RADIX; k++)
                begin
                    acc = acc | kid[k];
                end
            end

            always_ff @(posedge clk)
            begin
                tree_reg[DST_OFF + j] <= acc;
            end
        end
    end

    assign root = tree_reg[TOTAL - 1];

endmodule

/* rtl/indexed_shift_array_core.sv */
// ============================================================================
// indexed_shift_array_core - ordered word list with insert and delete
// Fixed-capacity array of words kept in a row of cells with a length count;
// append, read, overwrite, insert and delete by index, one transaction each.
// ============================================================================
//
// Usage:
//   in_ch  (sink)   : func, position, word_in. One request transaction per
//                     operation; func 0 append, 1 read, 2 overwrite,
//                     3 insert, 4 delete, other codes do nothing.
//   out_ch (source) : word_out, count, status. Exactly one response per
//                     request, in order. status 0 ok, 1 index out of range,
//                     2 array full; a rejected operation changes nothing.
// Timing:
//   One request is in flight at a time. After the request transaction the
//   controller executes the operation, then waits out the LEVELS register
//   stages of the radix-16 read tree (2 for 256 cells) before response valid
//   rises. Insert and delete shift every cell in the same cycle, so their
//   cost does not grow with the position; the read path through the tree
//   sets the response time.
// Reset:
//   rst_n clears the controller and the length; the cells hold no reset.
// Back-pressure:
//   The response stays valid and stable until out_ch.ready; no new request
//   is taken until the response has been taken.
// ============================================================================
module indexed_shift_array_core #(
    parameter int CAPACITY   = 256,
    parameter int DATA_WIDTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    isa_in_if.sink         in_ch,
    isa_out_if.source      out_ch
);

    localparam int LEN_W  = $clog2(CAPACITY + 1);
    localparam int LEVELS = isa_pkg::tree_levels(CAPACITY);
    localparam int WAIT_W = $clog2(LEVELS + 1);
    localparam int WORD_W = isa_pkg::WORD_W;
    localparam int POS_W  = isa_pkg::POS_W;

    // ------------------------------------------------------------------
    // Controller registers
    // ------------------------------------------------------------------
    isa_pkg::fsm_t                      state_reg,  state_next;
    logic [LEN_W-1:0]                   len_reg,    len_next;
    logic [WAIT_W-1:0]                  wait_reg,   wait_next;
    // Request and response payload
    logic [isa_pkg::FUNC_W-1:0]         func_reg,   func_next;
    logic [isa_pkg::POSITION_W-1:0]     pos_reg,    pos_next;
    logic [DATA_WIDTH-1:0]              word_reg,   word_next;
    isa_pkg::status_t                   status_reg, status_next;
    logic                               rd_ok_reg,  rd_ok_next;

    isa_pkg::cell_ctrl_t                ctrl;
    logic                               in_ready;
    logic                               out_valid;
    logic [DATA_WIDTH-1:0]              word_cut;
    logic [DATA_WIDTH-1:0]              root;
    logic [WORD_W-1:0]                  root_word;
    logic [POS_W-1:0]                   pos_ext;
    logic [POS_W-1:0]                   len_ext;
    logic                               pos_lt_len;
    logic                               pos_le_len;
    logic                               full;

    // Width adaptation between the 32-bit ports and the stored word
    if (DATA_WIDTH >= WORD_W)
    begin : g_wide
        assign word_cut  = DATA_WIDTH'(in_ch.word_in);
        assign root_word = root[WORD_W-1:0];
    end
    else
    begin : g_narrow
        assign word_cut  = in_ch.word_in[DATA_WIDTH-1:0];
        assign root_word = {{(WORD_W - DATA_WIDTH){1'b0}}, root};
    end

    if (LEN_W >= isa_pkg::COUNT_W)
    begin : g_cnt_cut
        assign out_ch.count = len_reg[isa_pkg::COUNT_W-1:0];
    end
    else
    begin : g_cnt_ext
        assign out_ch.count = {{(isa_pkg::COUNT_W - LEN_W){1'b0}}, len_reg};
    end

    assign pos_ext    = POS_W'(pos_reg);
    assign len_ext    = POS_W'(len_reg);
    assign pos_lt_len = (pos_ext < len_ext);
    assign pos_le_len = (pos_ext <= len_ext);
    assign full       = (len_reg == LEN_W'(CAPACITY));

    // ------------------------------------------------------------------
    // Next state, cell command and handshake
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        len_next    = len_reg;
        wait_next   = wait_reg;
        func_next   = func_reg;
        pos_next    = pos_reg;
        word_next   = word_reg;
        status_next = status_reg;
        rd_ok_next  = rd_ok_reg;
        ctrl.kind   = isa_pkg::CMD_NONE;
        ctrl.pos    = pos_ext;
        ctrl.len    = len_ext;
        in_ready    = 1'b0;
        out_valid   = 1'b0;

        case (state_reg)
            isa_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_ch.valid)
                begin
                    func_next  = in_ch.func;
                    pos_next   = in_ch.position;
                    word_next  = word_cut;
                    state_next = isa_pkg::S_EXEC;
                end
            end
            isa_pkg::S_EXEC:
            begin
                status_next = isa_pkg::ST_OK;
                rd_ok_next  = 1'b0;
                case (isa_pkg::op_t'(func_reg))
                    isa_pkg::OP_APPEND:
                    begin
                        if (full)
                        begin
                            status_next = isa_pkg::ST_FULL;
                        end
                        else
                        begin
                            ctrl.kind = isa_pkg::CMD_WRITE;
                            ctrl.pos  = len_ext;
                            len_next  = LEN_W'(len_reg + 1'b1);
                        end
                    end
                    isa_pkg::OP_READ:
                    begin
                        if (!pos_lt_len)
                        begin
                            status_next = isa_pkg::ST_RANGE;
                        end
                        else
                        begin
                            rd_ok_next = 1'b1;
                        end
                    end
                    isa_pkg::OP_WRITE:
                    begin
                        if (!pos_lt_len)
                        begin
                            status_next = isa_pkg::ST_RANGE;
                        end
                        else
                        begin
                            ctrl.kind = isa_pkg::CMD_WRITE;
                        end
                    end
                    isa_pkg::OP_INSERT:
                    begin
                        // index test takes precedence over the full test
                        if (!pos_le_len)
                        begin
                            status_next = isa_pkg::ST_RANGE;
                        end
                        else if (full)
                        begin
                            status_next = isa_pkg::ST_FULL;
                        end
                        else
                        begin
                            ctrl.kind = isa_pkg::CMD_INSERT;
                            len_next  = LEN_W'(len_reg + 1'b1);
                        end
                    end
                    isa_pkg::OP_DELETE:
                    begin
                        if (!pos_lt_len)
                        begin
                            status_next = isa_pkg::ST_RANGE;
                        end
                        else
                        begin
                            ctrl.kind = isa_pkg::CMD_DELETE;
                            len_next  = LEN_W'(len_reg - 1'b1);
                        end
                    end
                    default:
                    begin
                        status_next = isa_pkg::ST_OK;
                    end
                endcase
                // tree already took one sample at this edge
                if (LEVELS == 1)
                begin
                    state_next = isa_pkg::S_OUT;
                end
                else
                begin
                    wait_next  = WAIT_W'(LEVELS - 1);
                    state_next = isa_pkg::S_WAIT;
                end
            end
            isa_pkg::S_WAIT:
            begin
                wait_next = WAIT_W'(wait_reg - 1'b1);
                if (wait_reg == WAIT_W'(1))
                begin
                    state_next = isa_pkg::S_OUT;
                end
            end
            isa_pkg::S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ch.ready)
                begin
                    state_next = isa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = isa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= isa_pkg::S_IDLE;
            len_reg   <= '0;
            wait_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            wait_reg  <= wait_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        pos_reg    <= pos_next;
        word_reg   <= word_next;
        status_reg <= status_next;
        rd_ok_reg  <= rd_ok_next;
    end

    assign in_ch.ready     = in_ready;
    assign out_ch.valid    = out_valid;
    assign out_ch.status   = status_reg;
    assign out_ch.word_out = rd_ok_reg ? root_word : '0;

    // ------------------------------------------------------------------
    // Cell row and read tree
    // ------------------------------------------------------------------
    logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_leaf [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] lower;
        logic [DATA_WIDTH-1:0] upper;

        if (i == 0)
        begin : g_first
            assign lower = '0;
        end
        else
        begin : g_lower
            assign lower = cell_data[i - 1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign upper = '0;
        end
        else
        begin : g_upper
            assign upper = cell_data[i + 1];
        end

        isa_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .INDEX      (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .word       (word_reg),
            .lower_data (lower),
            .upper_data (upper),
            .data       (cell_data[i]),
            .leaf       (cell_leaf[i])
        );
    end

    isa_read_tree #(
        .DATA_WIDTH (DATA_WIDTH),
        .CAPACITY   (CAPACITY)
    ) u_tree (
        .clk  (clk),
        .leaf (cell_leaf),
        .root (root)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid))
        else $error("request taken while a response is pending");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(CAPACITY))
        else $error("length above capacity");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> (state_reg == isa_pkg::S_EXEC))
        else $error("accepted transaction not executed next cycle");

    a_reject_keeps_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == isa_pkg::S_EXEC && status_next != isa_pkg::ST_OK)
        |=> (len_reg == $past(len_reg)))
        else $error("rejected operation changed the length");

    a_len_only_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != isa_pkg::S_EXEC) |=> $stable(len_reg))
        else $error("length changed outside execution");

endmodule

/* tb/sv/indexed_shift_array_core_tb.sv */
// ============================================================================
// indexed_shift_array_core_tb - self-checking bench for the shift array core
// Feeds append, read, overwrite, insert, delete and unused opcodes through
// the request channel. A directed table comes first: empty list, full list,
// index limits and unused codes. A long random run follows, steered to
// drain the list and fill it again. Each accepted request updates a shadow
// copy of the list. The predicted response is queued and compared field by
// field with the response channel. Both sides idle at random, and the
// response side holds off once for a long stretch.
// ============================================================================
module indexed_shift_array_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY     = 256;
    localparam int DATA_WIDTH   = 32;
    localparam int FUNC_W       = isa_pkg::FUNC_W;
    localparam int POSITION_W   = isa_pkg::POSITION_W;
    localparam int WORD_W       = isa_pkg::WORD_W;
    localparam int COUNT_W      = isa_pkg::COUNT_W;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 10;    // idle stretch after the last response
    localparam int HOLD_CYCLES  = 300;   // long back-pressure stretch
    localparam int PHASE_ITEMS  = 420;   // random transactions per idle phase
    localparam int GOAL_ITEMS   = 260;   // transactions per fill goal

    // Unused opcodes: the block must treat these as no-ops
    localparam logic [FUNC_W-1:0] OP_SPARE_LO  = 3'd5;
    localparam logic [FUNC_W-1:0] OP_SPARE_MID = 3'd6;
    localparam logic [FUNC_W-1:0] OP_SPARE_HI  = 3'd7;

    typedef struct {
        logic [WORD_W-1:0]  resp_word;
        logic [COUNT_W-1:0] resp_count;
        isa_pkg::status_t   resp_status;
    } list_result_t;

    // One row of the directed table. Rows with reps > 1 repeat the request
    // with random words. Rows with known set carry a hand-written response;
    // the others are checked against the shadow list.
    typedef struct {
        logic [FUNC_W-1:0]     func;
        logic [POSITION_W-1:0] pos;
        logic [WORD_W-1:0]     word;
        int                    reps;
        bit                    known;
        list_result_t          resp;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    isa_in_if  req_ch ();
    isa_out_if rsp_ch ();

    indexed_shift_array_core #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (req_ch),
        .out_ch (rsp_ch)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Shadow list: the bench's own copy of the cells and the length
    // ------------------------------------------------------------------------
    logic [DATA_WIDTH-1:0] shadow_words [CAPACITY];
    int unsigned           shadow_len;

    list_result_t pending_results [$];   // predicted responses, oldest first
    dir_row_t     dir_rows [$];

    int  err_count     = 0;
    int  cycle_count   = 0;
    int  send_idle_pct = 12;
    int  recv_idle_pct = 46;
    int  fill_goal     = 0;              // length the random traffic heads for
    bit  hold_req      = 1'b0;
    bit  hold_done     = 1'b0;
    int  hold_left     = 0;

    // Apply one operation to the shadow list and return its response.
    // Rejected operations leave the list untouched.
    function automatic list_result_t apply_list_op(input logic [FUNC_W-1:0] func,
                                                   input logic [POSITION_W-1:0] pos,
                                                   input logic [WORD_W-1:0] word);
        list_result_t r;
        int unsigned  p;
        r.resp_word   = '0;
        r.resp_status = isa_pkg::ST_OK;
        p = pos;
        case (func)
            isa_pkg::OP_APPEND:
                if (shadow_len >= CAPACITY) r.resp_status = isa_pkg::ST_FULL;
                else
                begin
                    shadow_words[shadow_len] = DATA_WIDTH'(word);
                    shadow_len++;
                end
            isa_pkg::OP_READ:
                if (p >= shadow_len) r.resp_status = isa_pkg::ST_RANGE;
                else r.resp_word = WORD_W'(shadow_words[p]);
            isa_pkg::OP_WRITE:
                if (p >= shadow_len) r.resp_status = isa_pkg::ST_RANGE;
                else shadow_words[p] = DATA_WIDTH'(word);
            isa_pkg::OP_INSERT:
                // index test first, then the full test
                if (p > shadow_len) r.resp_status = isa_pkg::ST_RANGE;
                else if (shadow_len >= CAPACITY) r.resp_status = isa_pkg::ST_FULL;
                else
                begin
                    for (int i = shadow_len; i > p; i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[p] = DATA_WIDTH'(word);
                    shadow_len++;
                end
            isa_pkg::OP_DELETE:
                if (p >= shadow_len) r.resp_status = isa_pkg::ST_RANGE;
                else
                begin
                    for (int i = p; i + 1 < shadow_len; i++)
                        shadow_words[i] = shadow_words[i+1];
                    shadow_len--;
                end
            default: ;                   // unused codes change nothing
        endcase
        r.resp_count = COUNT_W'(shadow_len);
        return r;
    endfunction

    // Offer one request, wait for its transaction, then queue the response.
    // A typed-in response replaces the prediction; the shadow list is
    // updated either way.
    task automatic send_request(input logic [FUNC_W-1:0] func,
                                input logic [POSITION_W-1:0] pos,
                                input logic [WORD_W-1:0] word,
                                input bit known,
                                input list_result_t known_resp);
        int           gap;
        list_result_t predicted;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.func     <= func;
        req_ch.position <= pos;
        req_ch.word_in  <= word;
        do @(posedge clk); while (!req_ch.ready);
        predicted = apply_list_op(func, pos, word);
        pending_results.push_back(known ? known_resp : predicted);
    endtask

    // Random request steered toward fill_goal: far from the goal most
    // traffic grows or shrinks the list, near it the mix is even.
    task automatic send_random_request();
        logic [FUNC_W-1:0]     func;
        logic [POSITION_W-1:0] pos;
        int                    roll;
        int                    dir_roll;
        int                    len;
        bit                    grow;
        bit                    near;
        list_result_t          none;
        len  = shadow_len;
        near = (len > fill_goal - 16) && (len < fill_goal + 16);
        grow = (len < fill_goal);
        roll = $urandom_range(0, 99);
        dir_roll = $urandom_range(0, 99);
        if (roll < 5)
            func = FUNC_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
        else if (roll < (near ? 30 : 15))
            func = isa_pkg::OP_READ;
        else if (roll < (near ? 40 : 20))
            func = isa_pkg::OP_WRITE;
        else if (near ? (dir_roll < 50) : (grow == (dir_roll < 95)))
            func = ($urandom_range(0, 1) != 0) ? isa_pkg::OP_APPEND : isa_pkg::OP_INSERT;
        else
            func = isa_pkg::OP_DELETE;

        // Mostly valid indexes, with the edges and raw 9-bit values mixed in
        roll = $urandom_range(0, 99);
        if (roll < 8)       pos = POSITION_W'($urandom_range(0, 511));
        else if (roll < 14) pos = POSITION_W'(len);
        else if (roll < 18) pos = '0;
        else if (roll < 22) pos = POSITION_W'((len == 0) ? 0 : len - 1);
        else if (roll < 25) pos = POSITION_W'(len + 1);
        else                pos = POSITION_W'((len == 0) ? 0 : $urandom_range(0, len - 1));

        none = '{resp_status: isa_pkg::ST_OK, default: '0};
        send_request(func, pos, $urandom(), 1'b0, none);
    endtask

    // ------------------------------------------------------------------------
    // Cycle limit
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Response side: random ready, one long hold-off, in-order check
    // ------------------------------------------------------------------------
    initial
    begin
        list_result_t want;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("response with nothing pending: word_out %h count %0d status %0d",
                           rsp_ch.word_out, rsp_ch.count, rsp_ch.status);
                    err_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp_ch.word_out !== want.resp_word)
                    begin
                        $error("word_out: expected %h, got %h", want.resp_word, rsp_ch.word_out);
                        err_count++;
                    end
                    if (rsp_ch.count !== want.resp_count)
                    begin
                        $error("count: expected %0d, got %0d", want.resp_count, rsp_ch.count);
                        err_count++;
                    end
                    if (rsp_ch.status !== want.resp_status)
                    begin
                        $error("status: expected %0d, got %0d", want.resp_status, rsp_ch.status);
                        err_count++;
                    end
                end
            end
            // long hold-off, counted here; the request side keeps offering
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Reset, directed table, random traffic, drain and verdict
    // ------------------------------------------------------------------------
    initial
    begin
        list_result_t none;
        int           goal_list [6];
        int           n;

        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.func     <= '0;
        req_ch.position <= '0;
        req_ch.word_in  <= '0;
        foreach (shadow_words[i]) shadow_words[i] = '0;
        shadow_len = 0;
        none = '{resp_status: isa_pkg::ST_OK, default: '0};

        // Directed table. Empty-list rejects, unused codes, insert at the
        // end, a fill to capacity, full rejects and the index-first rule
        // for insert at a full list.
        dir_rows.push_back('{isa_pkg::OP_READ,   9'd0,   32'h0,        1, 1,
                             '{32'h0, 9'd0, isa_pkg::ST_RANGE}});
        dir_rows.push_back('{isa_pkg::OP_DELETE, 9'd0,   32'h0,        1, 1,
                             '{32'h0, 9'd0, isa_pkg::ST_RANGE}});
        dir_rows.push_back('{isa_pkg::OP_WRITE,  9'd0,   32'hFFFFFFFF, 1, 1,
                             '{32'h0, 9'd0, isa_pkg::ST_RANGE}});
        dir_rows.push_back('{isa_pkg::OP_INSERT, 9'd1,   32'hFFFFFFFF, 1, 1,
                             '{32'h0, 9'd0, isa_pkg::ST_RANGE}});
        dir_rows.push_back('{isa_pkg::OP_INSERT, 9'd0,   32'hFFFFFFFF, 1, 1,
                             '{32'h0, 9'd1, isa_pkg::ST_OK}});
        dir_rows.push_back('{isa_pkg::OP_APPEND, 9'd511, 32'h0,        1, 1,
                             '{32'h0, 9'd2, isa_pkg::ST_OK}});
        dir_rows.push_back('{isa_pkg::OP_READ,   9'd0,   32'h0,        1, 1,
                             '{32'hFFFFFFFF, 9'd2, isa_pkg::ST_OK}});
        dir_rows.push_back('{isa_pkg::OP_READ,   9'd1,   32'hFFFFFFFF, 1, 1,
                             '{32'h0, 9'd2, isa_pkg::ST_OK}});
        dir_rows.push_back('{isa_pkg::OP_READ,   9'd511, 32'h0,        1, 1,
                             '{32'h0, 9'd2, isa_pkg::ST_RANGE}});
        dir_rows.push_back('{OP_SPARE_LO,  9'd0,   32'hFFFFFFFF, 1, 1,
                             '{32'h0, 9'd2, isa_pkg::ST_OK}});
        dir_rows.push_back('{OP_SPARE_MID, 9'd1,   32'h0,        1, 1,
                             '{32'h0, 9'd2, isa_pkg::ST_OK}});
        dir_rows.push_back('{OP_SPARE_HI,  9'd511, 32'hFFFFFFFF, 1, 1,
                             '{32'h0, 9'd2, isa_pkg::ST_OK}});
        dir_rows.push_back('{isa_pkg::OP_WRITE,  9'd1,   32'hA5A5A5A5, 1, 1,
                             '{32'h0, 9'd2, isa_pkg::ST_OK}});
        dir_rows.push_back('{isa_pkg::OP_INSERT, 9'd2,   32'h5A5A5A5A, 1, 1,
                             '{32'h0, 9'd3, isa_pkg::ST_OK}});
        dir_rows.push_back('{isa_pkg::OP_INSERT, 9'd1,   32'h12345678, 1, 0, none});
        dir_rows.push_back('{isa_pkg::OP_DELETE, 9'd0,   32'h0,        1, 0, none});
        dir_rows.push_back('{isa_pkg::OP_READ,   9'd2,   32'h0,        1, 0, none});
        dir_rows.push_back('{isa_pkg::OP_APPEND, 9'd0,   32'h0,      253, 0, none});  // fill
        dir_rows.push_back('{isa_pkg::OP_APPEND, 9'd0,   32'hFFFFFFFF, 1, 1,
                             '{32'h0, 9'd256, isa_pkg::ST_FULL}});
        dir_rows.push_back('{isa_pkg::OP_INSERT, 9'd256, 32'hFFFFFFFF, 1, 1,
                             '{32'h0, 9'd256, isa_pkg::ST_FULL}});
        dir_rows.push_back('{isa_pkg::OP_INSERT, 9'd257, 32'h0,        1, 1,
                             '{32'h0, 9'd256, isa_pkg::ST_RANGE}});
        dir_rows.push_back('{isa_pkg::OP_INSERT, 9'd0,   32'h0,        1, 1,
                             '{32'h0, 9'd256, isa_pkg::ST_FULL}});
        dir_rows.push_back('{isa_pkg::OP_READ,   9'd255, 32'h0,        1, 0, none});
        dir_rows.push_back('{isa_pkg::OP_WRITE,  9'd255, 32'h0,        1, 1,
                             '{32'h0, 9'd256, isa_pkg::ST_OK}});
        dir_rows.push_back('{isa_pkg::OP_READ,   9'd256, 32'h0,        1, 1,
                             '{32'h0, 9'd256, isa_pkg::ST_RANGE}});
        dir_rows.push_back('{isa_pkg::OP_DELETE, 9'd255, 32'h0,        1, 1,
                             '{32'h0, 9'd255, isa_pkg::ST_OK}});
        dir_rows.push_back('{isa_pkg::OP_DELETE, 9'd255, 32'h0,        1, 1,
                             '{32'h0, 9'd255, isa_pkg::ST_RANGE}});
        dir_rows.push_back('{isa_pkg::OP_APPEND, 9'd0,   32'hFFFFFFFF, 1, 1,
                             '{32'h0, 9'd256, isa_pkg::ST_OK}});

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: sender idles lightly, receiver heavily
        send_idle_pct = 12;
        recv_idle_pct = 46;
        foreach (dir_rows[r])
        begin
            for (int k = 0; k < dir_rows[r].reps; k++)
                send_request(dir_rows[r].func, dir_rows[r].pos,
                             (dir_rows[r].reps > 1) ? 32'($urandom()) : dir_rows[r].word,
                             dir_rows[r].known, dir_rows[r].resp);
        end

        // Random part: three idle phases; the fill goal walks the list from
        // full down to empty, up to full again, then back down.
        goal_list = '{0, 64, CAPACITY, CAPACITY, 0, CAPACITY / 2};
        n = 0;
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 12; recv_idle_pct = 46; end
                1: begin send_idle_pct = 46; recv_idle_pct = 12; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                fill_goal = goal_list[(n / GOAL_ITEMS) % 6];
                if (n == 40) hold_req = 1'b1;
                send_random_request();
                n++;
            end
        end
        req_ch.valid <= 1'b0;

        // Drain: every predicted response must arrive, then nothing more
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
